FILE: design/fpe_pkg.sv
// shared constants, types and tables for the four-point pose estimator
// used by every module of the block, no dependencies
`default_nettype none

package fpe_pkg;

  localparam int PIXEL_BITS = 10;
  localparam int ANGLE_BITS = 16;

  // coordinate sums and centered deviations (deviation is 4*p - sum)
  localparam int SUM_W = PIXEL_BITS + 2;
  localparam int DEV_W = PIXEL_BITS + 4;
  localparam int SQ_W  = 2 * DEV_W - 3;
  localparam int Q_W   = SQ_W + 2;
  localparam int TERM_W = DEV_W + 14;
  localparam int ACC_W  = TERM_W + 4;

  // root of q * 2^24, one result bit per stage
  localparam int ROOT_FRAC   = 12;
  localparam int QPAD_W      = 2 * ((Q_W + 1) / 2);
  localparam int ROOT_STAGES = QPAD_W / 2 + ROOT_FRAC;
  localparam int ROOT_W      = ROOT_STAGES;
  localparam int REM_W       = ROOT_W + 4;

  // position scaling
  localparam int K_W     = 22;
  localparam logic [K_W-1:0] RINK_K = K_W'(2453393);
  localparam int NUM_W   = SUM_W + K_W + 2;
  localparam int DIV_W   = ROOT_W + 1;
  localparam int POS_W   = 16;
  localparam int CMP_W   = DIV_W + POS_W;
  localparam int DIV_LAT = POS_W + 2;

  // arctangent
  localparam int CORDIC_STEPS = 30;
  localparam int NORM_BIT     = 40;
  localparam int SH_W         = 6;
  localparam int X_W          = NORM_BIT + 4;
  localparam int Y_W          = X_W + 1;
  localparam int Z_W          = 33;
  localparam int MAG_W        = ANGLE_BITS - 1;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 3;
  localparam logic [MAG_W-1:0] QUARTER = MAG_W'(1 << (ANGLE_BITS - 2));

  // alignment of the two result paths
  localparam int POS_LAT = ROOT_STAGES + DIV_LAT;
  localparam int ANG_DLY = POS_LAT - CORDIC_LAT;

  localparam int NPTS = 4;

  // centered star pattern, 1/1000 cm
  localparam logic signed [15:0] STAR_U [0:NPTS-1] = '{
    -16'sd273, -16'sd273, -16'sd10836, 16'sd11382
  };
  localparam logic signed [15:0] STAR_V [0:NPTS-1] = '{
    16'sd11694, -16'sd17306, -16'sd323, 16'sd5935
  };

  // atan(2^-i) in units of pi/2^31
  localparam logic [31:0] ATAN_TBL [0:CORDIC_STEPS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic qnz;
    logic num_zero;
    logic den_zero;
    logic neg;
  } fpe_flags_t;

endpackage

`default_nettype wire

FILE: design/four_point_pose_estimator.sv
// four-point pose estimator, fully pipelined from accepted request to out_valid
// throughput one request per cycle unless stalled; all stages move on a single enable
// the enable drops only while a finished result sits in the output register stalled
// the position path (26-stage root plus 18-stage scaler) sets the depth
// synchronous active-low reset clears the valid bits only, payload registers are free
// depends on fpe_pkg, fpe_lane, fpe_isqrt, fpe_div, fpe_cordic
`default_nettype none

module four_point_pose_estimator (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [fpe_pkg::PIXEL_BITS-1:0]   in_pt0_x,
  input  wire logic [fpe_pkg::PIXEL_BITS-1:0]   in_pt0_y,
  input  wire logic [fpe_pkg::PIXEL_BITS-1:0]   in_pt1_x,
  input  wire logic [fpe_pkg::PIXEL_BITS-1:0]   in_pt1_y,
  input  wire logic [fpe_pkg::PIXEL_BITS-1:0]   in_pt2_x,
  input  wire logic [fpe_pkg::PIXEL_BITS-1:0]   in_pt2_y,
  input  wire logic [fpe_pkg::PIXEL_BITS-1:0]   in_pt3_x,
  input  wire logic [fpe_pkg::PIXEL_BITS-1:0]   in_pt3_y,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [15:0]                           out_pos_x,
  output logic [15:0]                           out_pos_y,
  output logic signed [15:0]                    out_heading,
  output logic                                  out_saturated,
  output logic                                  out_valid_res
);

  localparam int NP   = fpe_pkg::NPTS;
  localparam int PB   = fpe_pkg::PIXEL_BITS;
  localparam int SW   = fpe_pkg::SUM_W;
  localparam int AW   = fpe_pkg::ACC_W;
  localparam int PL   = fpe_pkg::POS_LAT;
  localparam int RL   = fpe_pkg::ROOT_STAGES;
  localparam int AD   = fpe_pkg::ANG_DLY;
  localparam int MW   = fpe_pkg::MAG_W;
  localparam int VLEN = PL + 3;

  // global pipeline enable: hold only when the output register is full and stalled
  logic en;
  logic out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // valid chain: capture, lanes, merge, then the aligned result paths
  logic vld_r [0:VLEN-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < VLEN; k++) vld_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < VLEN; k++) vld_r[k] <= vld_r[k-1];
      out_valid_r <= vld_r[VLEN-1];
    end
  end

  // capture stage: points and coordinate sums
  logic [PB-1:0] pin_x [0:NP-1];
  logic [PB-1:0] pin_y [0:NP-1];
  logic [PB-1:0] px_r  [0:NP-1];
  logic [PB-1:0] py_r  [0:NP-1];
  logic [SW-1:0] sx_r, sy_r;

  assign pin_x[0] = in_pt0_x;
  assign pin_y[0] = in_pt0_y;
  assign pin_x[1] = in_pt1_x;
  assign pin_y[1] = in_pt1_y;
  assign pin_x[2] = in_pt2_x;
  assign pin_y[2] = in_pt2_y;
  assign pin_x[3] = in_pt3_x;
  assign pin_y[3] = in_pt3_y;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NP; k++) begin
        px_r[k] <= pin_x[k];
        py_r[k] <= pin_y[k];
      end
      sx_r <= SW'(pin_x[0]) + SW'(pin_x[1]) + SW'(pin_x[2]) + SW'(pin_x[3]);
      sy_r <= SW'(pin_y[0]) + SW'(pin_y[1]) + SW'(pin_y[2]) + SW'(pin_y[3]);
    end
  end

  // one lane per point
  logic [fpe_pkg::SQ_W-1:0]          lane_sq  [0:NP-1];
  logic signed [fpe_pkg::TERM_W-1:0] lane_num [0:NP-1];
  logic signed [fpe_pkg::TERM_W-1:0] lane_den [0:NP-1];

  for (genvar g = 0; g < NP; g++) begin : g_lane
    fpe_lane u_lane (
      .clk    (clk),
      .en     (en),
      .px     (px_r[g]),
      .py     (py_r[g]),
      .sx     (sx_r),
      .sy     (sy_r),
      .star_u (fpe_pkg::STAR_U[g]),
      .star_v (fpe_pkg::STAR_V[g]),
      .sq_r   (lane_sq[g]),
      .num_r  (lane_num[g]),
      .den_r  (lane_den[g])
    );
  end

  // sums follow the lanes one stage
  logic [SW-1:0] sx_b_r, sy_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sx_b_r <= sx_r;
      sy_b_r <= sy_r;
    end
  end

  // merge stage: pattern energy and the two angle sums
  logic [fpe_pkg::Q_W-1:0] q_c_r;
  logic signed [AW-1:0]    num_c_r, den_c_r;
  logic [SW-1:0]           sx_c_r, sy_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_c_r <= fpe_pkg::Q_W'(lane_sq[0]) + fpe_pkg::Q_W'(lane_sq[1])
             + fpe_pkg::Q_W'(lane_sq[2]) + fpe_pkg::Q_W'(lane_sq[3]);
      num_c_r <= AW'(lane_num[0]) + AW'(lane_num[1]) + AW'(lane_num[2]) + AW'(lane_num[3]);
      den_c_r <= AW'(lane_den[0]) + AW'(lane_den[1]) + AW'(lane_den[2]) + AW'(lane_den[3]);
      sx_c_r  <= sx_b_r;
      sy_c_r  <= sy_b_r;
    end
  end

  // special-case flags ride alongside the long position path
  fpe_pkg::fpe_flags_t flags_c;
  fpe_pkg::fpe_flags_t flag_r [1:PL];

  always_comb begin
    flags_c.qnz      = (q_c_r != '0);
    flags_c.num_zero = (num_c_r == '0);
    flags_c.den_zero = (den_c_r == '0);
    flags_c.neg      = flags_c.num_zero ? den_c_r[AW-1] : (num_c_r[AW-1] ^ den_c_r[AW-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flag_r[1] <= flags_c;
      for (int k = 2; k <= PL; k++) flag_r[k] <= flag_r[k-1];
    end
  end

  // pattern size root
  logic [fpe_pkg::ROOT_W-1:0] root;

  fpe_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .q    (q_c_r),
    .root (root)
  );

  // sums wait for the root
  logic [SW-1:0] sxd_r [1:RL];
  logic [SW-1:0] syd_r [1:RL];

  always_ff @(posedge clk) begin
    if (en) begin
      sxd_r[1] <= sx_c_r;
      syd_r[1] <= sy_c_r;
      for (int k = 2; k <= RL; k++) begin
        sxd_r[k] <= sxd_r[k-1];
        syd_r[k] <= syd_r[k-1];
      end
    end
  end

  // one scaler per axis
  logic [15:0] pos_x, pos_y;
  logic        sat_x, sat_y;

  fpe_div u_div_x (
    .clk (clk),
    .en  (en),
    .s   (sxd_r[RL]),
    .r   (root),
    .pos (pos_x),
    .sat (sat_x)
  );

  fpe_div u_div_y (
    .clk (clk),
    .en  (en),
    .s   (syd_r[RL]),
    .r   (root),
    .pos (pos_y),
    .sat (sat_y)
  );

  // heading magnitude, then delayed to line up with position
  logic [MW-1:0] mag;
  logic [MW-1:0] magd_r [1:AD];

  fpe_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .num   (num_c_r),
    .den   (den_c_r),
    .mag_r (mag)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      magd_r[1] <= mag;
      for (int k = 2; k <= AD; k++) magd_r[k] <= magd_r[k-1];
    end
  end

  // output register: apply special cases and sign
  fpe_pkg::fpe_flags_t fl;
  logic [MW-1:0]       msel;
  logic [15:0]         pos_x_nxt, pos_y_nxt;
  logic signed [15:0]  head_nxt;
  logic                sat_nxt, vres_nxt;
  logic [15:0]         pos_x_r, pos_y_r;
  logic signed [15:0]  head_r;
  logic                sat_r, vres_r;

  always_comb begin
    fl        = flag_r[PL];
    pos_x_nxt = '0;
    pos_y_nxt = '0;
    head_nxt  = '0;
    sat_nxt   = 1'b0;
    vres_nxt  = 1'b0;
    msel      = '0;
    if (fl.qnz) begin
      pos_x_nxt = pos_x;
      pos_y_nxt = pos_y;
      sat_nxt   = sat_x | sat_y;
      if (!(fl.num_zero && fl.den_zero)) begin
        vres_nxt = 1'b1;
        // heading along the den axis when num vanishes
        if (fl.num_zero) msel = fpe_pkg::QUARTER;
        else if (fl.den_zero) msel = '0;
        else msel = magd_r[AD];
        head_nxt = fl.neg ? -$signed(16'(msel)) : $signed(16'(msel));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      head_r  <= head_nxt;
      sat_r   <= sat_nxt;
      vres_r  <= vres_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pos_x     = pos_x_r;
  assign out_pos_y     = pos_y_r;
  assign out_heading   = head_r;
  assign out_saturated = sat_r;
  assign out_valid_res = vres_r;

  // heading stays within a quarter turn either way
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading <= 16'sd16384 && out_heading >= -16'sd16384))
    else $error("heading out of range");

  // an undefined result carries no heading
  a_invalid_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_heading == 16'sd0))
    else $error("heading set on invalid result");

  // a clamp shows up in one of the positions
  a_sat_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> (out_pos_x == 16'hFFFF || out_pos_y == 16'hFFFF))
    else $error("saturated without clamped position");

  // a stalled result is held
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_pos_x) && $stable(out_heading)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: design/fpe_lane.sv
// one point lane: deviation, squared distance and star cross terms
// depends on fpe_pkg
`default_nettype none

module fpe_lane (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [fpe_pkg::PIXEL_BITS-1:0]    px,
  input  wire logic [fpe_pkg::PIXEL_BITS-1:0]    py,
  input  wire logic [fpe_pkg::SUM_W-1:0]         sx,
  input  wire logic [fpe_pkg::SUM_W-1:0]         sy,
  input  wire logic signed [15:0]                star_u,
  input  wire logic signed [15:0]                star_v,
  output logic [fpe_pkg::SQ_W-1:0]               sq_r,
  output logic signed [fpe_pkg::TERM_W-1:0]      num_r,
  output logic signed [fpe_pkg::TERM_W-1:0]      den_r
);

  localparam int DW = fpe_pkg::DEV_W;
  localparam int PW = 2 * DW;
  localparam int TW = DW + 16;

  logic signed [DW-1:0] dx, dy;
  logic signed [PW-1:0] sq_full;
  logic signed [TW-1:0] num_full, den_full;

  assign dx = $signed(DW'({px, 2'b00})) - $signed(DW'(sx));
  assign dy = $signed(DW'({py, 2'b00})) - $signed(DW'(sy));

  always_comb begin
    sq_full  = dx * dx + dy * dy;
    num_full = TW'(star_v * dx) - TW'(star_u * dy);
    den_full = TW'(star_u * dx) + TW'(star_v * dy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r  <= sq_full[fpe_pkg::SQ_W-1:0];
      num_r <= num_full[fpe_pkg::TERM_W-1:0];
      den_r <= den_full[fpe_pkg::TERM_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/fpe_isqrt.sv
// pipelined square root of q * 2^24, one result bit per stage
// depends on fpe_pkg
`default_nettype none

module fpe_isqrt (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [fpe_pkg::Q_W-1:0]     q,
  output logic [fpe_pkg::ROOT_W-1:0]       root
);

  localparam int QP = fpe_pkg::QPAD_W;
  localparam int N  = fpe_pkg::ROOT_STAGES;
  localparam int RW = fpe_pkg::REM_W;
  localparam int OW = fpe_pkg::ROOT_W;

  logic [QP-1:0] q_r    [1:N];
  logic [RW-1:0] rem_r  [1:N];
  logic [OW-1:0] root_r [1:N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [QP-1:0] q_s;
    logic [RW-1:0] rem_s, remx, trial;
    logic [OW-1:0] root_s;
    logic [1:0]    pair;

    if (j == 0) begin : g_first
      assign q_s    = QP'(q);
      assign rem_s  = '0;
      assign root_s = '0;
    end else begin : g_next
      assign q_s    = q_r[j];
      assign rem_s  = rem_r[j];
      assign root_s = root_r[j];
    end

    // low pairs of the shifted operand are zero
    if (j < QP / 2) begin : g_pair
      assign pair = q_s[QP-1-2*j -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign remx  = {rem_s[RW-3:0], pair};
    assign trial = RW'({root_s, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j+1] <= q_s;
        if (remx >= trial) begin
          rem_r[j+1]  <= remx - trial;
          root_r[j+1] <= {root_s[OW-2:0], 1'b1};
        end else begin
          rem_r[j+1]  <= remx;
          root_r[j+1] <= {root_s[OW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r[N];

endmodule

`default_nettype wire

FILE: design/fpe_div.sv
// position scaler: round(s * k / r) by restoring division, saturating at 16 bits
// depends on fpe_pkg
`default_nettype none

module fpe_div (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [fpe_pkg::SUM_W-1:0]    s,
  input  wire logic [fpe_pkg::ROOT_W-1:0]   r,
  output logic [fpe_pkg::POS_W-1:0]         pos,
  output logic                              sat
);

  localparam int NW = fpe_pkg::NUM_W;
  localparam int DW = fpe_pkg::DIV_W;
  localparam int CW = fpe_pkg::CMP_W;
  localparam int PW = fpe_pkg::POS_W;

  logic [NW-1:0] n_r;
  logic [DW-1:0] d0_r;

  logic [NW-1:0] rem_r [0:PW];
  logic [DW-1:0] d_r   [0:PW];
  logic          sat_r [0:PW];
  logic [PW-1:0] quo_r [0:PW];

  // numerator 2*s*k + r over 2*r gives the rounded quotient
  always_ff @(posedge clk) begin
    if (en) begin
      n_r  <= ((NW'(s) * NW'(fpe_pkg::RINK_K)) << 1) + NW'(r);
      d0_r <= {r, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= n_r;
      d_r[0]   <= d0_r;
      sat_r[0] <= CW'(n_r) >= {d0_r, {PW{1'b0}}};
      quo_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < PW; j++) begin : g_stage
    logic [CW-1:0] sub;
    logic          take;

    assign sub  = CW'(d_r[j]) << (PW - 1 - j);
    assign take = CW'(rem_r[j]) >= sub;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= take ? NW'(CW'(rem_r[j]) - sub) : rem_r[j];
        d_r[j+1]   <= d_r[j];
        sat_r[j+1] <= sat_r[j];
        quo_r[j+1] <= {quo_r[j][PW-2:0], take};
      end
    end
  end

  assign sat = sat_r[PW];
  assign pos = sat_r[PW] ? {PW{1'b1}} : quo_r[PW];

endmodule

`default_nettype wire

FILE: design/fpe_cordic.sv
// first-quadrant arctangent of |den|/|num|: normalize, vectoring cordic, round
// depends on fpe_pkg
`default_nettype none

module fpe_cordic (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [fpe_pkg::ACC_W-1:0]   num,
  input  wire logic signed [fpe_pkg::ACC_W-1:0]   den,
  output logic [fpe_pkg::MAG_W-1:0]               mag_r
);

  localparam int AW = fpe_pkg::ACC_W;
  localparam int XW = fpe_pkg::X_W;
  localparam int YW = fpe_pkg::Y_W;
  localparam int ZW = fpe_pkg::Z_W;
  localparam int N  = fpe_pkg::CORDIC_STEPS;
  localparam int SW = fpe_pkg::SH_W;
  localparam logic signed [ZW-1:0] ZMAX = ZW'(1 << 30);

  logic [AW-1:0] a_r, b_r;
  logic [SW-1:0] sh_r;
  logic [AW-1:0] a_abs, b_abs, m;
  logic [SW-1:0] msb;

  logic [XW-1:0]        x_r [0:N];
  logic signed [YW-1:0] y_r [0:N];
  logic signed [ZW-1:0] z_r [1:N];

  assign a_abs = num[AW-1] ? AW'(-num) : AW'(num);
  assign b_abs = den[AW-1] ? AW'(-den) : AW'(den);
  assign m     = a_abs | b_abs;

  always_comb begin
    msb = '0;
    for (int k = 0; k < AW; k++) begin
      if (m[k]) msb = SW'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= a_abs;
      b_r  <= b_abs;
      sh_r <= SW'(fpe_pkg::NORM_BIT) - msb;
    end
  end

  // double both until the larger reaches the normalizing bit
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= XW'(a_r) << sh_r;
      y_r[0] <= $signed(YW'(b_r) << sh_r);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [XW-1:0]        ymag;
    logic [XW-1:0]        xs;
    logic signed [ZW-1:0] z_s;

    if (i == 0) begin : g_z0
      assign z_s = '0;
    end else begin : g_zn
      assign z_s = z_r[i];
    end

    assign ymag = y_r[i][YW-1] ? XW'(-y_r[i]) : XW'(y_r[i]);
    assign xs   = x_r[i] >> i;

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= x_r[i] + (ymag >> i);
        if (!y_r[i][YW-1]) begin
          y_r[i+1] <= y_r[i] - $signed(YW'(xs));
          z_r[i+1] <= z_s + $signed(ZW'(fpe_pkg::ATAN_TBL[i]));
        end else begin
          y_r[i+1] <= y_r[i] + $signed(YW'(xs));
          z_r[i+1] <= z_s - $signed(ZW'(fpe_pkg::ATAN_TBL[i]));
        end
      end
    end
  end

  logic signed [ZW-1:0] zc;
  logic [31:0]          h;

  always_comb begin
    if (z_r[N] < 0) zc = '0;
    else if (z_r[N] > ZMAX) zc = ZMAX;
    else zc = z_r[N];
    h = (32'(zc) + 32'(1 << (31 - fpe_pkg::ANGLE_BITS))) >> (32 - fpe_pkg::ANGLE_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= (h > 32'(fpe_pkg::QUARTER)) ? fpe_pkg::QUARTER : h[fpe_pkg::MAG_W-1:0];
    end
  end

endmodule

`default_nettype wire
